// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache checker: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache checker: next-cycle implication failed");

`endif

// ===== rtl/core/sac_pkg.sv =====
// Types and constants of the set-associative write-back cache.
// Used by every module of the block; depends on nothing.
package sac_pkg;

	localparam int WORD_W     = 32;
	localparam int WORDS      = 4;
	localparam int WIDX_W     = 2;
	localparam int SET_W      = 4;
	localparam int TAG_W      = 4;
	localparam int WAYS       = 4;
	localparam int WAY_W      = 2;
	localparam int SETS       = 16;
	localparam int AGE_W      = 2;
	localparam int LIDX_W     = SET_W + WAY_W;
	localparam int BLK_W      = TAG_W + SET_W;
	localparam int MEM_BLOCKS = 1 << BLK_W;
	localparam int LINES      = SETS * WAYS;
	localparam int COST_W     = 16;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [1:0] {
		FN_READ  = 2'd0,
		FN_WRITE = 2'd1,
		FN_FLUSH = 2'd2,
		FN_NONE  = 2'd3
	} func_e_t;

	typedef enum logic [1:0] {
		REG_HIT       = 2'd0,
		REG_FILL      = 2'd1,
		REG_WRITEBACK = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef logic [WORDS-1:0][WORD_W-1:0] line_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  ack_kind;
		logic        hit;
		logic [3:0]  set_num;
		logic [15:0] cost_cycles;
		logic [31:0] read_data;
	} rsp_t;

	typedef struct packed {
		func_e_t           func;
		logic [TAG_W-1:0]  tag;
		logic [SET_W-1:0]  set;
		logic [WIDX_W-1:0] widx;
		logic [WORD_W-1:0] wdata;
	} op_t;

	typedef struct packed {
		logic [7:0] hit_cycles;
		logic [9:0] fill_cycles;
		logic [9:0] writeback_cycles;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} meta_t;

endpackage

// ===== rtl/core/sac_front.sv =====
// Front end: accepts request items, splits the address and queues decoded items.
// Depends on sac_pkg.
module sac_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sac_pkg::req_t req,
	output logic          op_valid,
	output sac_pkg::op_t  op,
	input  logic          op_pop
);
	import sac_pkg::*;

	op_t        fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        dec;
	logic       push;

	always_comb begin
		dec.func  = func_e_t'(req.func);
		dec.widx  = req.address[3:2];
		dec.set   = req.address[7:4];
		dec.tag   = req.address[11:8];
		dec.wdata = req.write_data;
	end

	assign req_ready = (count_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign op_valid  = (count_q != 2'd0);
	assign op        = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, op_pop};
		end
	end

endmodule

// ===== rtl/core/sac_back.sv =====
// Back end: tag lookup, LRU update, write-back, fill, flush walk and the result register.
// Holds the line data store and the backing memory. Depends on sac_pkg.
module sac_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sac_pkg::cfg_t cfg,
	input  logic          op_valid,
	input  sac_pkg::op_t  op,
	output logic          op_pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sac_pkg::rsp_t rsp
);
	import sac_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_WB, S_FILL_RD, S_FILL_WR, S_ACC_RD, S_ACC,
		S_FL_RD, S_FL_WR, S_DONE
	} state_t;

	state_t            state_q;
	op_t               op_q;
	meta_t             meta_q [SETS][WAYS];
	logic [WAY_W-1:0]  way_q;
	logic              hit_q;
	logic              wb_q;
	logic [LIDX_W-1:0] fl_cnt_q;
	logic [16:0]       fl_acc_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	line_t             line_mem [LINES];
	line_t             ld_rdata_q;
	line_t             bm_mem [MEM_BLOCKS];
	logic              bm_valid_q [MEM_BLOCKS];
	line_t             bm_rdata_q;
	logic              bm_rvld_q;

	logic [SET_W-1:0]  meta_set;
	meta_t             row [WAYS];
	meta_t             new_row [WAYS];
	logic              hit;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  victim;
	logic              any_inv;
	logic [WAY_W-1:0]  fl_way;
	logic [LIDX_W-1:0] ld_raddr;
	logic              ld_we;
	line_t             ld_wdata;
	logic              bm_we;
	logic [BLK_W-1:0]  bm_waddr;
	line_t             bm_eff;
	line_t             merged;
	logic [AGE_W:0]    old_age;
	logic [11:0]       rw_cost;
	logic              slot_free;

	assign fl_way   = fl_cnt_q[WAY_W-1:0];
	assign meta_set = (state_q == S_FL_RD || state_q == S_FL_WR) ?
		fl_cnt_q[LIDX_W-1:WAY_W] : op_q.set;
	assign bm_eff   = bm_rvld_q ? bm_rdata_q : '0;

	always_comb begin
		for (int k = 0; k < WAYS; k++) begin
			row[k] = meta_q[meta_set][k];
		end
		hit     = 1'b0;
		hit_way = '0;
		for (int k = WAYS - 1; k >= 0; k--) begin
			if (row[k].valid && row[k].tag == op_q.tag) begin
				hit     = 1'b1;
				hit_way = WAY_W'(k);
			end
		end
		// First invalid way, else the oldest with the lowest way number on a tie.
		any_inv = 1'b0;
		victim  = '0;
		for (int k = WAYS - 1; k >= 0; k--) begin
			if (!row[k].valid) begin
				any_inv = 1'b1;
				victim  = WAY_W'(k);
			end
		end
		if (!any_inv) begin
			for (int k = WAYS - 1; k >= 0; k--) begin
				if (row[k].age >= row[victim].age) begin
					victim = WAY_W'(k);
				end
			end
		end
	end

	// Recency update for the way being accessed, plus its new tag and dirty mark.
	always_comb begin
		old_age = row[way_q].valid ? {1'b0, row[way_q].age} : (AGE_W + 1)'(WAYS);
		for (int k = 0; k < WAYS; k++) begin
			new_row[k] = row[k];
			if (WAY_W'(k) != way_q && row[k].valid && {1'b0, row[k].age} < old_age) begin
				new_row[k].age = row[k].age + 1'b1;
			end
		end
		new_row[way_q].age   = '0;
		new_row[way_q].tag   = op_q.tag;
		new_row[way_q].valid = 1'b1;
		if (op_q.func == FN_WRITE) begin
			new_row[way_q].dirty = 1'b1;
		end else if (!hit_q) begin
			new_row[way_q].dirty = 1'b0;
		end
	end

	always_comb begin
		merged            = ld_rdata_q;
		merged[op_q.widx] = op_q.wdata;
		case (state_q)
			S_LOOK:  ld_raddr = {op_q.set, victim};
			S_FL_RD: ld_raddr = fl_cnt_q;
			default: ld_raddr = {op_q.set, way_q};
		endcase
		ld_we    = (state_q == S_FILL_WR) || (state_q == S_ACC && op_q.func == FN_WRITE);
		ld_wdata = (state_q == S_FILL_WR) ? bm_eff : merged;
		bm_we    = (state_q == S_WB) || (state_q == S_FL_WR);
		bm_waddr = (state_q == S_WB) ? {row[way_q].tag, op_q.set} :
			{row[fl_way].tag, meta_set};
		rw_cost  = 12'(cfg.hit_cycles) + (wb_q ? 12'(cfg.writeback_cycles) : 12'd0) +
			(hit_q ? 12'd0 : 12'(cfg.fill_cycles));
	end

	always_ff @(posedge clk) begin
		ld_rdata_q <= line_mem[ld_raddr];
		if (ld_we) begin
			line_mem[{op_q.set, way_q}] <= ld_wdata;
		end
	end

	always_ff @(posedge clk) begin
		bm_rdata_q <= bm_mem[{op_q.tag, op_q.set}];
		if (bm_we) begin
			bm_mem[bm_waddr] <= ld_rdata_q;
		end
	end

	// A backing block never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < MEM_BLOCKS; b++) begin
				bm_valid_q[b] <= 1'b0;
			end
			bm_rvld_q <= 1'b0;
		end else begin
			bm_rvld_q <= bm_valid_q[{op_q.tag, op_q.set}];
			if (bm_we) begin
				bm_valid_q[bm_waddr] <= 1'b1;
			end
		end
	end

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign op_pop    = (state_q == S_IDLE) && op_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			op_q        <= '0;
			way_q       <= '0;
			hit_q       <= 1'b0;
			wb_q        <= 1'b0;
			fl_cnt_q    <= '0;
			fl_acc_q    <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			for (int s = 0; s < SETS; s++) begin
				for (int k = 0; k < WAYS; k++) begin
					meta_q[s][k] <= '0;
				end
			end
		end else begin
			// The result slot is refilled in S_DONE in the same cycle it drains.
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						op_q     <= op;
						res_q    <= '{ack_kind: op.func, default: '0};
						fl_cnt_q <= '0;
						fl_acc_q <= '0;
						wb_q     <= 1'b0;
						case (op.func)
							FN_FLUSH: state_q <= S_FL_RD;
							FN_NONE:  state_q <= S_DONE;
							default:  state_q <= S_LOOK;
						endcase
					end
				end
				S_LOOK: begin
					hit_q <= hit;
					way_q <= hit ? hit_way : victim;
					if (hit) begin
						state_q <= S_ACC_RD;
					end else if (row[victim].valid && row[victim].dirty) begin
						wb_q    <= 1'b1;
						state_q <= S_WB;
					end else begin
						state_q <= S_FILL_RD;
					end
				end
				S_WB:      state_q <= S_FILL_RD;
				S_FILL_RD: state_q <= S_FILL_WR;
				S_FILL_WR: state_q <= S_ACC_RD;
				S_ACC_RD:  state_q <= S_ACC;
				S_ACC: begin
					for (int k = 0; k < WAYS; k++) begin
						meta_q[op_q.set][k] <= new_row[k];
					end
					res_q <= '{ack_kind: op_q.func, hit: hit_q, set_num: op_q.set,
						cost_cycles: COST_W'(rw_cost),
						read_data: (op_q.func == FN_READ) ? ld_rdata_q[op_q.widx] : '0};
					state_q <= S_DONE;
				end
				S_FL_RD: begin
					if (row[fl_way].valid && row[fl_way].dirty) begin
						state_q <= S_FL_WR;
					end else if (fl_cnt_q == LIDX_W'(LINES - 1)) begin
						res_q.cost_cycles <= fl_acc_q[16] ? '1 : fl_acc_q[15:0];
						state_q <= S_DONE;
					end else begin
						fl_cnt_q <= fl_cnt_q + 1'b1;
					end
				end
				S_FL_WR: begin
					meta_q[meta_set][fl_way].dirty <= 1'b0;
					fl_acc_q <= fl_acc_q + 17'(cfg.writeback_cycles);
					state_q  <= S_FL_RD;
				end
				S_DONE: begin
					if (slot_free) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/set_assoc_writeback_cache.sv =====
// Channel  | Direction | Handshake              | Payload
// req      | in        | req_valid / req_ready  | sac_pkg::req_t
// rsp      | out       | rsp_valid / rsp_ready  | sac_pkg::rsp_t
// cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
// A read or write hit passes S_LOOK, S_ACC_RD, S_ACC and S_DONE from dequeue to result;
// a miss adds S_FILL_RD and S_FILL_WR for the fill, and S_WB for a dirty write-back.
// A flush walks all 64 lines: S_FL_RD for each, plus S_FL_WR for each dirty line.
// Reset is immediate: backing memory blocks carry valid bits, so no clearing pass runs.
// A two-item queue and the result register let either side stall on its own.
module set_assoc_writeback_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sac_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sac_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [9:0]    cfg_data
);
	import sac_pkg::*;

	cfg_t cfg_q;
	logic op_valid;
	op_t  op;
	logic op_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_cycles       <= 8'd1;
			cfg_q.fill_cycles      <= 10'd10;
			cfg_q.writeback_cycles <= 10'd10;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_HIT:       cfg_q.hit_cycles       <= cfg_data[7:0];
				REG_FILL:      cfg_q.fill_cycles      <= cfg_data;
				REG_WRITEBACK: cfg_q.writeback_cycles <= cfg_data;
				default: ;
			endcase
		end
	end

	sac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop)
	);

	sac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/sac_checker.sv =====
// Port-level checker for the cache, bound to the top level.
// Depends on sac_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sac_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sac_pkg::rsp_t rsp
);
	import sac_pkg::*;

	`SAC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`SAC_ASSERT_IMP(a_hit_kind, rsp_valid && rsp.hit, rsp.ack_kind != FN_FLUSH && rsp.ack_kind != FN_NONE)
	`SAC_ASSERT_IMP(a_flush_fields, rsp_valid && rsp.ack_kind == FN_FLUSH, !rsp.hit && rsp.set_num == 4'd0)
	`SAC_ASSERT_IMP(a_rdata_zero, rsp_valid && rsp.ack_kind != FN_READ, rsp.read_data == 32'd0)

endmodule

bind set_assoc_writeback_cache sac_checker u_sac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
